@@ rtl/pawo_pkg.sv @@
// shared types and codes of the phase accumulator waveform oscillator
// no dependencies; imported by pawo_in_if, the sine rom and the top level
package pawo_pkg;

    localparam int OPCODE_W      = 2;
    localparam int PHASE_VALUE_W = 32;
    localparam int WAVE_W        = 2;
    localparam int STEP_W        = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // pi/2 in q30, seed of the quarter-wave sine series
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [WAVE_W-1:0]   t_wave;
    typedef logic                t_reg_idx;

    localparam t_opcode OP_NEXT = 2'd0;
    localparam t_opcode OP_MOD  = 2'd1;
    localparam t_opcode OP_AT   = 2'd2;
    localparam t_opcode OP_LOAD = 2'd3;

    localparam t_wave WAVE_SINE   = 2'd0;
    localparam t_wave WAVE_SQUARE = 2'd1;
    localparam t_wave WAVE_TRI    = 2'd2;
    localparam t_wave WAVE_SAW    = 2'd3;

    localparam t_reg_idx REG_WAVE = 1'b0;
    localparam t_reg_idx REG_STEP = 1'b1;

endpackage

@@ rtl/pawo_if.sv @@
// valid/ready channel interfaces of the oscillator: command in, sample out
// depends on pawo_pkg
interface pawo_in_if import pawo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_opcode                  opcode;
    logic [PHASE_VALUE_W-1:0] phase_value;

    modport source (output valid, output opcode, output phase_value, input ready);
    modport sink   (input valid, input opcode, input phase_value, output ready);
endinterface

interface pawo_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/pawo_sine_rom.sv @@
// quarter-wave sine rom with registered read, contents built at elaboration
// depends on pawo_pkg
module pawo_sine_rom import pawo_pkg::*; #(
    parameter int ADDR_BITS   = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [ADDR_BITS:0]     i_addr,
    output logic [SAMPLE_BITS-1:0] o_data
);

    localparam int DEPTH = (1 << ADDR_BITS) + 1;
    localparam longint unsigned FULL = 64'd1 << (SAMPLE_BITS - 1);

    // round(sin(pi/2 * k/N) * full scale), q30 taylor series
    function automatic logic [SAMPLE_BITS-1:0] sine_entry(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (HALF_PI_Q30 * 64'(k)) >> ADDR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 10; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * FULL + (64'd1 << 29)) >> 30;
        if (v > FULL) begin
            v = FULL;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    logic [SAMPLE_BITS-1:0] w_table [DEPTH];
    logic [SAMPLE_BITS-1:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        assign w_table[g] = sine_entry(g);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_table[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

@@ rtl/phase_accumulator_waveform_oscillator.sv @@
// Numerically controlled oscillator. A phase accumulator of PHASE_BITS bits
// (a fraction of a full turn, wrapping) drives one of four waveforms chosen by
// the waveform_select register: sine from a quarter-wave rom, square, triangle
// or sawtooth, as signed samples with SAMPLE_BITS - 1 fraction bits and +1
// saturated to the largest positive code. Each command transaction either
// emits the next sample and advances by phase_step, emits a sample at phase
// plus an offset (wrapping) and advances, emits a sample at an absolute phase,
// or loads the phase and emits nothing. One command is taken every clock
// unless the output is stalled; an accepted command passes the sine stage
// (phase add and registered read of the sine rom), then the output
// register. Output back-pressure stalls the sine stage and then the input.
// Registers sit on an apb port at byte address 0 (waveform_select) and
// 4 (phase_step); write them only while the block is idle.
// depends on pawo_pkg, pawo_if and pawo_sine_rom
module phase_accumulator_waveform_oscillator import pawo_pkg::*; #(
    parameter int PHASE_BITS           = 32,
    parameter int SAMPLE_BITS          = 16,
    parameter int SINE_TABLE_ADDR_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    pawo_in_if.sink               i_in,
    // sample channel
    pawo_out_if.source            o_out,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int A     = SINE_TABLE_ADDR_BITS;
    localparam int SB    = SAMPLE_BITS;
    localparam int PB    = PHASE_BITS;
    // bits of a 32-bit phase field that reach the accumulator
    localparam int PV_W  = (PB < PHASE_VALUE_W) ? PB : PHASE_VALUE_W;
    localparam int EXT_W = PB + SB + 1;

    localparam logic [SB-1:0] POS_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] NEG_MAX = {1'b1, {(SB-1){1'b0}}};
    localparam logic [A:0]    QTR_N   = {1'b1, {A{1'b0}}};

    // ---------------- configuration registers ----------------
    t_wave              r_wave;
    logic [STEP_W-1:0]  r_step;
    logic               w_cfg_wr;
    t_reg_idx           w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= WAVE_SINE;
            r_step <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_WAVE: r_wave <= pwdata[WAVE_W-1:0];
                REG_STEP: r_step <= pwdata[STEP_W-1:0];
                default:  r_step <= r_step;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_WAVE: prdata = APB_DATA_W'(r_wave);
            REG_STEP: prdata = APB_DATA_W'(r_step);
            default:  prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic w_out_free;
    logic w_s1_move;
    logic w_accept;

    // the output register frees when empty or taken this cycle
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign i_in.ready = !r_s1_valid || w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;

    // ---------------- stage 0: phase select and accumulator ----------------
    logic [PB-1:0] r_phase;
    logic [PB-1:0] w_pv;
    logic [PB-1:0] w_step_p;
    logic [PB-1:0] w_ph;

    // phase field and tuning word cut or widened to the accumulator width
    assign w_pv     = PB'(i_in.phase_value[PV_W-1:0]);
    assign w_step_p = PB'(r_step[PV_W-1:0]);

    always_comb begin
        case (i_in.opcode)
            OP_NEXT: w_ph = r_phase;
            OP_MOD:  w_ph = r_phase + w_pv;   // offset wraps with the sum
            default: w_ph = w_pv;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_accept) begin
            case (i_in.opcode)
                OP_NEXT, OP_MOD: r_phase <= r_phase + w_step_p;
                OP_LOAD:         r_phase <= w_pv;
                default:         r_phase <= r_phase;
            endcase
        end
    end

    // sine: quadrant from the top two bits, then the table index
    logic [1:0]   w_quad;
    logic [A-1:0] w_k;
    logic [A:0]   w_rom_addr;

    assign w_quad     = w_ph[PB-1 -: 2];
    assign w_k        = w_ph[PB-3 -: A];
    // odd quadrants mirror the quarter wave
    assign w_rom_addr = w_quad[0] ? (QTR_N - {1'b0, w_k}) : {1'b0, w_k};

    // floor(p * 2^bits) for the triangle and sawtooth is a top slice
    logic [EXT_W-1:0] w_ext;
    logic [SB:0]      w_tri_u;
    logic [SB-1:0]    w_saw_u;
    logic [SB:0]      w_tri_d;
    logic [SB:0]      w_tri_v;
    logic [SB-1:0]    w_other;
    logic             w_half;

    assign w_ext   = {w_ph, {(SB + 1){1'b0}}};
    assign w_tri_u = w_ext[EXT_W-1 -: SB + 1];
    assign w_saw_u = w_ext[EXT_W-1 -: SB];
    assign w_half  = (w_ph == {1'b1, {(PB-1){1'b0}}});

    // |u - 2^S| and then minus full scale
    assign w_tri_d = w_tri_u[SB] ? {1'b0, w_tri_u[SB-1:0]} : ((SB+1)'(1) << SB) - w_tri_u;
    assign w_tri_v = w_tri_d - (SB+1)'({1'b0, NEG_MAX});

    always_comb begin
        case (r_wave)
            WAVE_SQUARE: begin
                if (w_ph == '0 || w_half) begin
                    w_other = '0;
                end else if (!w_ph[PB-1]) begin
                    w_other = POS_MAX;   // +1 saturates
                end else begin
                    w_other = NEG_MAX;
                end
            end
            WAVE_TRI: begin
                // zero phase gives +1, saturated
                w_other = (w_tri_u == '0) ? POS_MAX : w_tri_v[SB-1:0];
            end
            default: begin
                // sawtooth: subtracting full scale flips the top bit
                w_other = {~w_saw_u[SB-1], w_saw_u[SB-2:0]};
            end
        endcase
    end

    // ---------------- stage 1: sine rom read ----------------
    logic          r_s1_sine;
    logic          r_s1_neg;
    logic [SB-1:0] r_s1_other;
    logic [SB-1:0] w_rom_data;
    logic [SB-1:0] w_sine;
    logic [SB-1:0] w_s1_sample;

    // the rom output only reloads with stage 1, so it holds through a stall
    pawo_sine_rom #(
        .ADDR_BITS   (A),
        .SAMPLE_BITS (SB)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_accept),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= (i_in.opcode != OP_LOAD);
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sine  <= (r_wave == WAVE_SINE);
            r_s1_neg   <= w_quad[1];
            r_s1_other <= w_other;
        end
    end

    // negating full scale leaves the same code, which is -1 exactly
    assign w_sine = r_s1_neg ? (SB'(0) - w_rom_data)
                             : (w_rom_data[SB-1] ? POS_MAX : w_rom_data);
    assign w_s1_sample = r_s1_sine ? w_sine : r_s1_other;

    // ---------------- output register ----------------
    logic [SB-1:0] r_out_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_sample <= w_s1_sample;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = $signed(r_out_sample);

    // ---------------- assertions ----------------
    // a held sine stage with a blocked output must block new commands
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("command accepted over a stalled sine stage");

    // a phase load takes the phase field
    a_load_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.opcode == OP_LOAD) |=> (r_phase == $past(w_pv)))
        else $error("phase load lost");

    // a next-sample command advances by the tuning word
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.opcode == OP_NEXT) |=>
            (r_phase == $past(r_phase + w_step_p)))
        else $error("phase did not advance by the tuning word");

    // a load produces no sample
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.opcode == OP_LOAD) |=> !r_s1_valid)
        else $error("phase load produced a sample");

endmodule
